/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clk outside reset.
`define PVEF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pvef: assertion failed");

// Next-cycle implication.
`define PVEF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pvef: assertion failed");

`else

`define PVEF_ASSERT(label, ante, cons)
`define PVEF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/pvef_pkg.sv */
package pvef_pkg;

  // Defaults for the top-level size parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Field widths
  localparam int PIX_W = 8;
  localparam int RGB_W = 3 * PIX_W;
  localparam int SUM_W = 10;
  localparam int CFG_W = 11;

  // Register reset values
  localparam logic [CFG_W-1:0] CFG_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] CFG_HEIGHT_RST = CFG_W'(480);

  // Register index (byte address bit 2)
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  // One column of the 3x3 window: center pixel and per-channel column sums
  typedef struct packed {
    logic [2:0][SUM_W-1:0] sum;
    logic [RGB_W-1:0]      center;
  } col_t;

  // Control handed to the window datapath with each item
  typedef struct packed {
    logic restart;   // last pixel of the frame: clear the window afterwards
    logic border;    // result passes the center pixel through
  } win_ctl_t;

  // Truncating divide by 3 for 0..765: multiply by 683/2048
  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] mag);
    logic [2*SUM_W-1:0] prod;
    prod = mag * SUM_W'(683);
    return prod[18:11];
  endfunction

endpackage

/* rtl/prewitt_vertical_edge_filter_core.sv */
// Channel  | Handshake          | Payload
// ---------+--------------------+---------------------------------------------
// in       | in_valid, in_stall | in_func, in_red, in_green, in_blue
// out      | out_valid, out_stall| out_red, out_green, out_blue, out_frame_end
// cfg      | APB (pready = 1)   | image_width @ 0x0, image_height @ 0x4
//
// One item per cycle while in_stall is low; the RAM read and the window datapath
// each take one register stage, so a released result passes the compute stage
// and the output register (image_width+1 items after its own pixel).
// rst_n is synchronous; the line stores have no reset and no clearing pass.
// in_stall rises only while the compute stage holds an item whose result the
// output register cannot take.
`include "assert_macros.svh"

module prewitt_vertical_edge_filter_core import pvef_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  // result items
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_red,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_blue,
  output logic             out_frame_end,
  // configuration
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);   // width value
  localparam int RW = $clog2(MAX_HEIGHT + 1);  // row index / height value
  localparam int LW = $clog2(MAX_WIDTH + 2);   // lag count up to width+1

  function automatic logic [WW-1:0] eff_w(input logic [CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) return WW'(1);
    if (v32 > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
    return WW'(v32);
  endfunction

  function automatic logic [RW-1:0] eff_h(input logic [CFG_W-1:0] v);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) return RW'(1);
    if (v32 > 32'(MAX_HEIGHT)) return RW'(MAX_HEIGHT);
    return RW'(v32);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers, raw for readback and clamped for use
  logic             cfg_wr;
  logic [CFG_W-1:0] width_r, height_r;
  logic [WW-1:0]    w_eff_r;
  logic [RW-1:0]    h_eff_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_IMAGE_HEIGHT) ? 32'(height_r) : 32'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_WIDTH_RST;
      height_r <= CFG_HEIGHT_RST;
      w_eff_r  <= eff_w(CFG_WIDTH_RST);
      h_eff_r  <= eff_h(CFG_HEIGHT_RST);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_IMAGE_WIDTH) begin
        width_r <= cfg_pwdata[CFG_W-1:0];
        w_eff_r <= eff_w(cfg_pwdata[CFG_W-1:0]);
      end else begin
        height_r <= cfg_pwdata[CFG_W-1:0];
        h_eff_r  <= eff_h(cfg_pwdata[CFG_W-1:0]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: positions, lag and result bookkeeping on the counters
  logic [CW-1:0] in_column_r, in_column_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_column_r, out_column_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;
  logic [LW-1:0] lag_r, lag_nxt;

  logic in_accept, drain, go;
  logic in_col_last, lag_full, out_col_last, out_row_last;
  logic s0_border, s0_fend;

  assign in_accept    = in_valid && !in_stall;
  assign drain        = in_func || (in_row_r >= h_eff_r);
  // a drain with nothing of this frame received is dropped
  assign go           = in_accept && !(drain && (lag_r == '0));
  assign in_col_last  = (WW'(in_column_r) + WW'(1)) >= w_eff_r;
  assign lag_full     = lag_r >= (LW'(w_eff_r) + LW'(1));
  assign out_col_last = (WW'(out_column_r) + WW'(1)) >= w_eff_r;
  assign out_row_last = (out_row_r + RW'(1)) >= h_eff_r;
  assign s0_border    = (out_row_r == '0) || out_row_last || (out_column_r == '0)
                      || out_col_last;
  assign s0_fend      = out_row_last && out_col_last;

  always_comb begin
    in_column_nxt  = in_column_r;
    in_row_nxt     = in_row_r;
    out_column_nxt = out_column_r;
    out_row_nxt    = out_row_r;
    lag_nxt        = lag_r;
    if (cfg_wr) begin
      in_column_nxt  = '0;
      in_row_nxt     = '0;
      out_column_nxt = '0;
      out_row_nxt    = '0;
      lag_nxt        = '0;
    end else if (go) begin
      if (in_col_last) begin
        in_column_nxt = '0;
        if (in_row_r < h_eff_r) begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end else begin
        in_column_nxt = in_column_r + CW'(1);
      end
      if (!lag_full) begin
        lag_nxt = lag_r + LW'(1);
      end else if (s0_fend) begin
        // frame done: start over
        in_column_nxt  = '0;
        in_row_nxt     = '0;
        out_column_nxt = '0;
        out_row_nxt    = '0;
        lag_nxt        = '0;
      end else if (out_col_last) begin
        out_column_nxt = '0;
        out_row_nxt    = out_row_r + RW'(1);
      end else begin
        out_column_nxt = out_column_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_column_r  <= '0;
      in_row_r     <= '0;
      out_column_r <= '0;
      out_row_r    <= '0;
      lag_r        <= '0;
    end else begin
      in_column_r  <= in_column_nxt;
      in_row_r     <= in_row_nxt;
      out_column_r <= out_column_nxt;
      out_row_r    <= out_row_nxt;
      lag_r        <= lag_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage registers
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_emit_r, s1_top_en_r, s1_mid_en_r;
  win_ctl_t         s1_ctl_r;
  logic [RGB_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_fire;

  // bypass for a read of the entry written at the same edge (one-pixel rows)
  logic             fwd_r;
  logic [RGB_W-1:0] fwd_top_r, fwd_mid_r;

  logic [2*RGB_W-1:0] rd_word;
  logic [RGB_W-1:0]   s1_top_val, s1_mid_val;
  logic [RGB_W-1:0]   res_rgb;

  assign s1_fire  = s1_valid_r && (!s1_emit_r || !out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;

  assign s1_valid_nxt = go ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_emit_r        <= lag_full;
      s1_ctl_r.border  <= s0_border;
      s1_ctl_r.restart <= lag_full && s0_fend;
      s1_top_en_r      <= in_row_r >= RW'(2);
      s1_mid_en_r      <= in_row_r >= RW'(1);
      s1_pix_r         <= drain ? '0 : {in_blue, in_green, in_red};
      s1_col_r         <= in_column_r;
      fwd_r            <= s1_fire && (s1_col_r == in_column_r);
      fwd_top_r        <= s1_mid_val;
      fwd_mid_r        <= s1_pix_r;
    end
  end

  // Upper row in the high half, middle row in the low half
  always_comb begin
    s1_top_val = '0;
    s1_mid_val = '0;
    if (s1_top_en_r) begin
      s1_top_val = fwd_r ? fwd_top_r : rd_word[2*RGB_W-1:RGB_W];
    end
    if (s1_mid_en_r) begin
      s1_mid_val = fwd_r ? fwd_mid_r : rd_word[RGB_W-1:0];
    end
  end

  pvef_ram #(
    .WIDTH (2 * RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata ({s1_mid_val, s1_pix_r}),
    .re    (go),
    .raddr (in_column_r),
    .rdata (rd_word)
  );

  pvef_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (cfg_wr),
    .fire    (s1_fire),
    .ctl     (s1_ctl_r),
    .top     (s1_top_val),
    .mid     (s1_mid_val),
    .pix     (s1_pix_r),
    .res_rgb (res_rgb)
  );

  // ---------------------------------------------------------------------------
  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [RGB_W-1:0] out_rgb_r;
  logic             out_fend_r;

  assign out_valid_nxt = (s1_fire && s1_emit_r) ? 1'b1
                       : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_rgb_r  <= res_rgb;
      out_fend_r <= s1_ctl_r.restart;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_rgb_r[PIX_W-1:0];
  assign out_green     = out_rgb_r[2*PIX_W-1:PIX_W];
  assign out_blue      = out_rgb_r[3*PIX_W-1:2*PIX_W];
  assign out_frame_end = out_fend_r;

  // ---------------------------------------------------------------------------
  // Checks; after a frame restart the first item may share column 0 with the
  // item before it, but it sits in row 0 and reads nothing
  `PVEF_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_col_r))
  `PVEF_ASSERT(a_fwd_one_col, s1_valid_r && fwd_r, (w_eff_r == WW'(1)) || !s1_mid_en_r)
  `PVEF_ASSERT_NEXT(a_fend_restart, go && lag_full && s0_fend,
                    (in_column_r == '0) && (lag_r == '0) && (out_row_r == '0))
  `PVEF_ASSERT(a_lag_bound, 1'b1, lag_r <= (LW'(w_eff_r) + LW'(1)))
  `PVEF_ASSERT(a_col_bound, 1'b1, WW'(in_column_r) < w_eff_r)

endmodule

/* rtl/pvef_ram.sv */
module pvef_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; a read of the address being
  // written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/pvef_window.sv */
module pvef_window import pvef_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             fire,
  input  win_ctl_t         ctl,
  input  logic [RGB_W-1:0] top,
  input  logic [RGB_W-1:0] mid,
  input  logic [RGB_W-1:0] pix,
  output logic [RGB_W-1:0] res_rgb
);

  // Window columns left of the incoming one: mid_col becomes the left
  // column and right_col the center column once the new column shifts in
  col_t mid_col_r, mid_col_nxt;
  col_t right_col_r, right_col_nxt;
  col_t new_col;
  logic [2:0][PIX_W-1:0] grad;

  // Column sums of the incoming column
  always_comb begin
    new_col.center = mid;
    for (int k = 0; k < 3; k++) begin
      new_col.sum[k] = SUM_W'(top[k*PIX_W +: PIX_W]) + SUM_W'(mid[k*PIX_W +: PIX_W])
                     + SUM_W'(pix[k*PIX_W +: PIX_W]);
    end
  end

  // Right column minus left column, magnitude over 3
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (new_col.sum[k] >= mid_col_r.sum[k]) begin
        grad[k] = div3(new_col.sum[k] - mid_col_r.sum[k]);
      end else begin
        grad[k] = div3(mid_col_r.sum[k] - new_col.sum[k]);
      end
    end
    res_rgb = ctl.border ? right_col_r.center : grad;
  end

  // Shift on each item; a frame restart or a register write empties the window
  always_comb begin
    mid_col_nxt   = mid_col_r;
    right_col_nxt = right_col_r;
    if (clear) begin
      mid_col_nxt   = '0;
      right_col_nxt = '0;
    end else if (fire) begin
      if (ctl.restart) begin
        mid_col_nxt   = '0;
        right_col_nxt = '0;
      end else begin
        mid_col_nxt   = right_col_r;
        right_col_nxt = new_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_col_r   <= '0;
      right_col_r <= '0;
    end else begin
      mid_col_r   <= mid_col_nxt;
      right_col_r <= right_col_nxt;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import pvef_pkg::*;

  localparam int MAX_W = DEF_MAX_WIDTH;
  localparam int MAX_H = DEF_MAX_HEIGHT;

  // item kinds on in_func
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // cycles allowed after the last result before touching the registers
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASES        = 12;
  localparam int REPORT_CAP    = 40;

  // 3x3 frame with a hard left/right edge, {blue, green, red}
  localparam logic [RGB_W-1:0] EDGE_FRAME [9] = '{
    24'h1100FF, 24'h808080, 24'h11FF00,
    24'hC800FF, 24'h030201, 24'hC8FF00,
    24'h0000FF, 24'h63584D, 24'hFFFF00
  };

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } out_pixel_t;

  // Tracks the filter state and holds the pixels it still owes
  class vert_edge_predictor;
    logic [RGB_W-1:0] upper_row [MAX_W];
    logic [RGB_W-1:0] middle_row [MAX_W];
    col_t             window [3];
    int unsigned      col_in, row_in, col_out, row_out, fill_count;
    logic [CFG_W-1:0] width_reg, height_reg;
    out_pixel_t       pending_pixels [$];
    int unsigned      errors, checked, items_taken;

    function new();
      width_reg   = CFG_WIDTH_RST;
      height_reg  = CFG_HEIGHT_RST;
      errors      = 0;
      checked     = 0;
      items_taken = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 3; i++) window[i] = '0;
      col_in     = 0;
      row_in     = 0;
      col_out    = 0;
      row_out    = 0;
      fill_count = 0;
    endfunction

    function int unsigned frame_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned frame_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function bit pixels_open();
      return row_in < frame_height();
    endfunction

    function bit frame_busy();
      return fill_count != 0;
    endfunction

    // any register write starts a new frame; line stores keep their contents
    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = value[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = value[CFG_W-1:0];
        default: ;
      endcase
      restart();
    endfunction

    function void take_pixel_item(logic func, logic [PIX_W-1:0] red, green, blue);
      int unsigned      w, h, col;
      logic             drain, border;
      logic [RGB_W-1:0] pix, top, mid, center;
      logic [SUM_W-1:0] lsum, rsum, mag;
      logic [PIX_W-1:0] chan [3];
      out_pixel_t       res;
      w = frame_width();
      h = frame_height();
      // data past the last row counts as a drain
      drain = (func == FUNC_DRAIN) || (row_in >= h);
      if (drain && fill_count == 0) return;
      items_taken++;
      pix = drain ? '0 : {blue, green, red};

      // line stores: rows above the first read as black
      col = (col_in >= MAX_W) ? 0 : col_in;
      top = (row_in >= 2) ? upper_row[col] : '0;
      mid = (row_in >= 1) ? middle_row[col] : '0;
      upper_row[col]  = mid;
      middle_row[col] = pix;

      // shift in the new column
      window[0] = window[1];
      window[1] = window[2];
      window[2].center = mid;
      for (int k = 0; k < 3; k++)
        window[2].sum[k] = SUM_W'(top[PIX_W*k +: PIX_W]) + SUM_W'(mid[PIX_W*k +: PIX_W]) +
                           SUM_W'(pix[PIX_W*k +: PIX_W]);

      if (col_in + 1 >= w) begin
        col_in = 0;
        if (row_in < 'hFFFF) row_in++;
      end else begin
        col_in++;
      end

      // nothing comes out until the window has caught up
      if (fill_count < w + 1) begin
        fill_count++;
        return;
      end

      center = window[1].center;
      border = (row_out == 0) || (row_out + 1 >= h) || (col_out == 0) || (col_out + 1 >= w);
      for (int k = 0; k < 3; k++) begin
        if (border) begin
          chan[k] = center[PIX_W*k +: PIX_W];
        end else begin
          rsum    = window[2].sum[k];
          lsum    = window[0].sum[k];
          mag     = (rsum >= lsum) ? rsum - lsum : lsum - rsum;
          chan[k] = PIX_W'(mag / 3);
        end
      end
      res.red       = chan[0];
      res.green     = chan[1];
      res.blue      = chan[2];
      res.frame_end = (row_out + 1 >= h) && (col_out + 1 >= w);
      pending_pixels.push_back(res);

      if (res.frame_end) begin
        restart();
      end else if (col_out + 1 >= w) begin
        col_out = 0;
        row_out++;
      end else begin
        col_out++;
      end
    endfunction

    function void compare(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void match_out_pixel(logic [PIX_W-1:0] red, green, blue, logic frame_end);
      out_pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected pixel, expected none, got rgb %0d %0d %0d end %0b",
                   $time, red, green, blue, frame_end);
        return;
      end
      want = pending_pixels.pop_front();
      checked++;
      compare("red", want.red, red);
      compare("green", want.green, green);
      compare("blue", want.blue, blue);
      compare("frame_end", PIX_W'(want.frame_end), PIX_W'(frame_end));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_func = FUNC_PIXEL;
  logic [PIX_W-1:0] in_red = '0;
  logic [PIX_W-1:0] in_green = '0;
  logic [PIX_W-1:0] in_blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             out_frame_end;
  logic             cfg_psel = 1'b0;
  logic             cfg_penable = 1'b0;
  logic             cfg_pwrite = 1'b0;
  logic [2:0]       cfg_paddr = '0;
  logic [31:0]      cfg_pwdata = '0;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  int unsigned        tx_gap_pct = 20;
  int unsigned        rx_stall_pct = 85;
  vert_edge_predictor board;

  prewitt_vertical_edge_filter_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always #4 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // check every pixel taken from the block
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_out_pixel(out_red, out_green, out_blue, out_frame_end);
  end

  // mostly random levels, with full-scale values often enough for strong edges
  function automatic logic [PIX_W-1:0] rand_level();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // one item on the input channel, with random idle cycles ahead of it
  task automatic push_item(input logic func, input logic [PIX_W-1:0] red, green, blue);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_red   <= red;
    in_green <= green;
    in_blue  <= blue;
    do @(posedge clk); while (in_stall);
    board.take_pixel_item(func, red, green, blue);
  endtask

  task automatic push_random_pixel();
    push_item(FUNC_PIXEL, rand_level(), rand_level(), rand_level());
  endtask

  // APB write: setup then access, finished when pready is seen
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    board.set_register(idx, value);
    @(posedge clk);
  endtask

  // block idle: every owed pixel delivered, pipeline given time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // push out the tail of the frame; data items here count as drains
  task automatic close_frame();
    while (board.frame_busy()) begin
      if ($urandom_range(3) == 0)
        push_random_pixel();
      else
        push_item(FUNC_DRAIN, rand_level(), rand_level(), rand_level());
    end
    // occasionally a drain with nothing pending
    if ($urandom_range(7) == 0)
      push_item(FUNC_DRAIN, rand_level(), rand_level(), rand_level());
  endtask

  // one register setting: whole frames with random content until the budget runs out
  task automatic run_phase(input logic [31:0] width_val, height_val, input int unsigned budget);
    int unsigned start;
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, width_val);
    cfg_write(REG_IMAGE_HEIGHT, height_val);
    start = board.items_taken;
    while (board.items_taken - start < budget) begin
      while (board.pixels_open() && board.items_taken - start < budget) begin
        if ($urandom_range(99) < 4)
          push_item(FUNC_DRAIN, rand_level(), rand_level(), rand_level());
        else
          push_random_pixel();
      end
      // out of budget mid-frame: the next register write restarts it
      if (board.pixels_open()) break;
      close_frame();
    end
  endtask

  initial begin
    logic [31:0] width_val, height_val;
    int unsigned budget;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // drain right after reset is ignored
    push_item(FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    cfg_write(REG_IMAGE_WIDTH, 32'd3);
    cfg_write(REG_IMAGE_HEIGHT, 32'd3);

    // strongest possible edges in red and green at the one interior pixel
    for (int i = 0; i < 9; i++)
      push_item(FUNC_PIXEL, EDGE_FRAME[i][7:0], EDGE_FRAME[i][15:8], EDGE_FRAME[i][23:16]);
    close_frame();

    // drain inside the frame becomes a black pixel; data after the last row counts as a drain
    for (int i = 0; i < 4; i++) push_item(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    push_item(FUNC_DRAIN, 8'hAA, 8'h55, 8'hAA);
    for (int i = 0; i < 4; i++) push_item(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
    push_item(FUNC_PIXEL, 8'd200, 8'd100, 8'd50);
    close_frame();

    for (int p = 0; p < PHASES; p++) begin
      // sender light / receiver heavy, then swapped, then free running
      if (p == 4) begin
        tx_gap_pct   = 85;
        rx_stall_pct = 20;
      end else if (p == 8) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      case (p)
        0: begin width_val = 0; height_val = 5; budget = 60; end
        2: begin width_val = 2047; height_val = 1024; budget = 1030; end
        4: begin width_val = 2; height_val = 2; budget = 50; end
        6: begin width_val = 1; height_val = 2047; budget = 50; end
        8: begin width_val = 6; height_val = 0; budget = 50; end
        default: begin
          width_val  = $urandom_range(10, 3);
          height_val = $urandom_range(6, 3);
          budget     = 55;
        end
      endcase
      run_phase(width_val, height_val, budget);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Ran %0d items through %0d register settings; %0d filtered pixels compared.",
             board.items_taken, PHASES + 1, board.checked);
    if (board.errors == 0 && board.pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Timed out with %0d pixels still owed", board.pending_pixels.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
